// ===== src/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared codes and types for the KISS frame deframer.
// ----------------------------------------------------------------------------
package kfd_pkg;

  localparam logic [7:0] KISS_FEND  = 8'hC0;
  localparam logic [7:0] KISS_FESC  = 8'hDB;
  localparam logic [7:0] KISS_TFEND = 8'hDC;
  localparam logic [7:0] KISS_TFESC = 8'hDD;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  // configuration register indexes
  localparam logic CFG_PORT_OPEN   = 1'b0;
  localparam logic CFG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    EV_TYPE = 2'd0,
    EV_BYTE = 2'd1,
    EV_END  = 2'd2,
    EV_DROP = 2'd3
  } ev_kind_t;

  // one parser outcome: whether a result is produced, and its fields
  typedef struct packed {
    logic       has;
    ev_kind_t   kind;
    logic [7:0] data;
  } ev_t;

endpackage

// ===== src/kiss_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// kiss_frame_deframer
// KISS receive deframer: one raw byte in, at most one framing event out.
// ----------------------------------------------------------------------------
// Path: input register, then result register, from input to result request.
// Throughput: one byte per cycle, set by the parser update, except while
//   an event byte waits for a full result slot to drain.
// Reset (rst_n low, synchronous): both stages empty, parser waits for an
//   opening FEND, port closed, capacity 1024.
// ----------------------------------------------------------------------------
module kiss_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // event output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] event_byte
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import kfd_pkg::*;

  // config registers
  logic        port_open_r;
  logic [15:0] max_payload_r;

  // input stage
  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  // result stage
  logic        out_vld_r;
  ev_kind_t    out_kind_r;
  logic [7:0]  out_byte_r;

  ev_t  ev;
  logic out_free;
  logic step;

  // Result slot is free when empty or being drained this cycle. A byte that
  // makes no event retires regardless of the slot.
  assign out_free  = !out_vld_r || out_tready;
  assign step      = in_vld_r && (!ev.has || out_free);
  assign in_tready = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_open_r   <= 1'b0;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PORT_OPEN:   port_open_r   <= cfg_data[0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  kfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step),
    .rx_byte     (in_byte_r),
    .port_open   (port_open_r),
    .max_payload (max_payload_r),
    .ev          (ev)
  );

  // result register: loads on an event, clears once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && ev.has) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ev.has) begin
      out_kind_r <= ev.kind;
      out_byte_r <= ev.data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;

  // --- assertions ---

  // closed port never produces an event
  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !port_open_r) |-> !ev.has)
    else $error("event produced while port closed");

  // end and drop events carry a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == EV_END || out_kind_r == EV_DROP)) |-> out_byte_r == 8'h00)
    else $error("non-zero byte on end/drop event");

  // an event never overwrites a pending unaccepted result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !(step && ev.has))
    else $error("pending result overwritten");

  // a stalled input byte is retained until it retires
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !step) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("input byte lost while stalled");

endmodule

// ===== src/kfd_parser.sv =====
// ----------------------------------------------------------------------------
// kfd_parser
// KISS framing state and per-byte decode; state advances on step_en.
// ----------------------------------------------------------------------------
module kfd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [7:0]     rx_byte,
  input  logic           port_open,
  input  logic [15:0]    max_payload,
  output kfd_pkg::ev_t   ev
);
  import kfd_pkg::*;

  typedef enum logic [1:0] {
    MODE_BEGIN   = 2'd0,
    MODE_TYPE    = 2'd1,
    MODE_PAYLOAD = 2'd2,
    MODE_ESCAPED = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] count_r, count_nxt;
  logic        room;

  assign room = (count_r < max_payload);

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    ev        = '{has: 1'b0, kind: EV_TYPE, data: 8'h00};
    if (port_open) begin
      unique case (mode_r)
        MODE_BEGIN: begin
          if (rx_byte == KISS_FEND) mode_nxt = MODE_TYPE;
        end
        MODE_TYPE: begin
          if (rx_byte != KISS_FEND) begin
            count_nxt = '0;
            mode_nxt  = MODE_PAYLOAD;
            ev        = '{has: 1'b1, kind: EV_TYPE, data: rx_byte};
          end
        end
        MODE_PAYLOAD: begin
          if (rx_byte == KISS_FESC) begin
            mode_nxt = MODE_ESCAPED;
          end else if (rx_byte == KISS_FEND) begin
            mode_nxt = MODE_BEGIN;
            ev       = '{has: 1'b1, kind: EV_END, data: 8'h00};
          end else if (room) begin
            count_nxt = count_r + 16'd1;
            ev        = '{has: 1'b1, kind: EV_BYTE, data: rx_byte};
          end else begin
            mode_nxt = MODE_BEGIN;
            ev       = '{has: 1'b1, kind: EV_DROP, data: 8'h00};
          end
        end
        MODE_ESCAPED: begin
          if ((rx_byte == KISS_TFESC || rx_byte == KISS_TFEND) && room) begin
            count_nxt = count_r + 16'd1;
            mode_nxt  = MODE_PAYLOAD;
            ev        = '{has: 1'b1, kind: EV_BYTE,
                          data: (rx_byte == KISS_TFESC) ? KISS_FESC : KISS_FEND};
          end else begin
            // bad escape, or escaped byte past capacity
            mode_nxt = MODE_BEGIN;
            ev       = '{has: 1'b1, kind: EV_DROP, data: 8'h00};
          end
        end
        default: mode_nxt = MODE_BEGIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BEGIN;
      count_r <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for kiss_frame_deframer. A behavioural model of the
// KISS parser runs beside the block and predicts each event. The bench first
// runs short directed frames: closed port, framing, escapes and capacity
// limits. It then holds the event side off for a long stretch, and finally
// sends random frames in phases. Each phase sets its capacity, whether the
// sender idles between bursts, and a receiver stall mode.
// ----------------------------------------------------------------------------
module tb;
  import kfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // watchdog, far above a clean run
  localparam int DRAIN_SLACK = 8;       // cycles after the last event
  localparam int DRAIN_LIMIT = 5000;    // give up waiting for stragglers

  // parser state of the model
  typedef enum logic [1:0] {
    P_HUNT = 2'd0,   // waiting for an opening FEND
    P_TYPE = 2'd1,   // waiting for the type byte
    P_BODY = 2'd2,   // in payload
    P_ESC  = 2'd3    // just seen FESC
  } parse_st_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    ev_kind_t   kind;
    logic [7:0] data;
  } deframe_ev_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] event_byte
  logic [1:0]  out_tuser;  // [1:0] event_kind
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  kiss_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model state and the events it still expects
  // --------------------------------------------------------------------------
  logic          m_open;
  logic [15:0]   m_cap;
  parse_st_t     m_mode;
  logic [15:0]   m_count;
  deframe_ev_t   exp_events[$];

  int n_accepted = 0;  // input requests taken by the block
  int n_cfg      = 0;  // register writes taken
  int n_sent     = 0;  // bytes sent by the stimulus
  int n_fail     = 0;
  int cycles     = 0;

  // stimulus knobs
  rx_mode_t rx_mode   = RX_ALWAYS;
  bit       tx_gaps   = 1'b0;
  int       hold_left = 0;   // receiver hold-off, counted down by the receiver
  int       burst_left = 0;

  // one unescaped payload byte: taken while below capacity, else the frame is dropped
  function automatic bit take_payload(input logic [7:0] c, output deframe_ev_t ev);
    if (m_count < m_cap) begin
      m_count = m_count + 16'd1;
      m_mode  = P_BODY;
      ev.kind = EV_BYTE;
      ev.data = c;
    end else begin
      m_mode  = P_HUNT;
      ev.kind = EV_DROP;
      ev.data = 8'h00;
    end
    return 1'b1;
  endfunction

  // advance the model by one received byte; returns 1 when an event is due
  function automatic bit deframe_step(input logic [7:0] c, output deframe_ev_t ev);
    bit has = 1'b0;
    ev.kind = EV_TYPE;
    ev.data = 8'h00;
    if (!m_open) return 1'b0;   // closed port: byte ignored, state kept
    case (m_mode)
      P_HUNT: begin
        if (c == KISS_FEND) m_mode = P_TYPE;
      end
      P_TYPE: begin
        // repeated FENDs keep us waiting for the type
        if (c != KISS_FEND) begin
          m_count = 16'd0;
          m_mode  = P_BODY;
          ev.kind = EV_TYPE;
          ev.data = c;
          has     = 1'b1;
        end
      end
      P_BODY: begin
        if (c == KISS_FESC) begin
          m_mode = P_ESC;
        end else if (c == KISS_FEND) begin
          m_mode  = P_HUNT;
          ev.kind = EV_END;
          has     = 1'b1;
        end else begin
          has = take_payload(c, ev);
        end
      end
      default: begin
        if (c == KISS_TFESC) begin
          has = take_payload(KISS_FESC, ev);
        end else if (c == KISS_TFEND) begin
          has = take_payload(KISS_FEND, ev);
        end else begin
          // bad escape drops the frame
          m_mode  = P_HUNT;
          ev.kind = EV_DROP;
          has     = 1'b1;
        end
      end
    endcase
    return has;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. The check comes before the
  // prediction, although an event can never leave in the cycle its byte enters.
  // --------------------------------------------------------------------------
  deframe_ev_t mon_ev;
  deframe_ev_t mon_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      m_open  = 1'b0;
      m_cap   = MAX_PAYLOAD_RST;
      m_mode  = P_HUNT;
      m_count = 16'd0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (exp_events.size() == 0) begin
          $error("unexpected event: kind %0d byte %02h", out_tuser, out_tdata);
          n_fail++;
        end else begin
          mon_want = exp_events.pop_front();
          if (out_tuser !== mon_want.kind) begin
            $error("event_kind: expected %0d, got %0d", mon_want.kind, out_tuser);
            n_fail++;
          end
          if (out_tdata !== mon_want.data) begin
            $error("event_byte: expected %02h, got %02h", mon_want.data, out_tdata);
            n_fail++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PORT_OPEN) m_open = cfg_data[0];
        else                            m_cap  = cfg_data;
        n_cfg++;
      end
      if (in_tvalid && in_tready) begin
        if (deframe_step(in_tdata, mon_ev)) exp_events.insert(exp_events.size(), mon_ev);
        n_accepted++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls on its own pattern, changed at the falling edge. A long
  // hold-off, when asked for, is counted down here cycle by cycle.
  // --------------------------------------------------------------------------
  initial begin
    logic [6:0] pat;
    pat = 7'b1100101;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_tready = 1'b1;
          RX_RANDOM: out_tready = ($urandom_range(0, 3) != 0);
          default: begin
            out_tready = pat[0];
            pat = {pat[0], pat[6:1]};
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. All tasks are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // one byte request; valid stays high after it unless a gap follows
  task automatic send_byte(input logic [7:0] c);
    int seen;
    seen      = n_accepted;
    in_tdata  = c;
    in_tvalid = 1'b1;
    do @(negedge clk); while (n_accepted == seen);
    n_sent++;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    int seen;
    seen      = n_cfg;
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(negedge clk); while (n_cfg == seen);
    cfg_valid = 1'b0;
  endtask

  // wait until every expected event is out, then let the pipe empty fully,
  // since bytes that give no event may still be in flight
  task automatic settle();
    int waited = 0;
    in_tvalid = 1'b0;
    while (exp_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // a mostly well-formed frame with random content, plus some noise:
  // missing opening FEND, bad escapes, raw specials, missing close
  task automatic send_frame(input logic [15:0] cap);
    int len;
    int r;
    if ($urandom_range(0, 19) != 0) repeat ($urandom_range(1, 2)) send_byte(KISS_FEND);
    send_byte(8'($urandom_range(0, 255)));
    len = $urandom_range(0, (cap < 10) ? int'(cap) + 1 : 10);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_byte(KISS_FESC);
        send_byte(KISS_TFEND);
      end else if (r < 20) begin
        send_byte(KISS_FESC);
        send_byte(KISS_TFESC);
      end else if (r < 23) begin
        send_byte(KISS_FESC);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(KISS_FEND);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // port closed out of reset; a closed port must also keep the parser state
  task automatic test_closed_port();
    send_byte(KISS_FEND);
    send_byte(8'h10);
    settle();
    write_reg(CFG_PORT_OPEN, 16'd1);
    send_byte(KISS_FEND);          // now waiting for the type
    settle();
    write_reg(CFG_PORT_OPEN, 16'd0);
    send_byte(8'h55);              // ignored, must not become the type
    settle();
    write_reg(CFG_PORT_OPEN, 16'd1);
    send_byte(8'h33);              // type 0x33
    send_byte(KISS_FEND);          // empty frame
  endtask

  // framing and escapes at the reset capacity
  task automatic test_framing();
    settle();
    send_byte(KISS_FEND);
    send_byte(KISS_FEND);          // repeated FEND before the type
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(KISS_FESC);
    send_byte(KISS_TFEND);         // escaped FEND
    send_byte(KISS_FESC);
    send_byte(KISS_TFESC);         // escaped FESC
    send_byte(KISS_FEND);          // close
    send_byte(8'h22);              // no opening FEND: ignored
    send_byte(KISS_FEND);
    send_byte(KISS_FESC);          // FESC as a type byte
    send_byte(KISS_FEND);          // empty frame
  endtask

  task automatic test_capacity();
    settle();
    write_reg(CFG_MAX_PAYLOAD, 16'd1);
    send_byte(KISS_FEND);
    send_byte(8'h10);
    send_byte(KISS_FESC);
    send_byte(8'h41);              // bad escape drops
    send_byte(KISS_FEND);
    send_byte(8'h11);
    send_byte(8'hAA);
    send_byte(KISS_FESC);          // at capacity: no event yet
    send_byte(KISS_TFEND);         // the escaped byte drops the frame
    settle();
    write_reg(CFG_MAX_PAYLOAD, 16'd0);  // zero: first payload byte drops
    send_byte(KISS_FEND);
    send_byte(8'h12);
    send_byte(8'hAA);
    settle();
    write_reg(CFG_MAX_PAYLOAD, 16'd3);
    send_byte(KISS_FEND);
    send_byte(8'h13);
    send_byte(8'hA1);
    send_byte(8'hA2);
    settle();
    write_reg(CFG_MAX_PAYLOAD, 16'd1);  // lowered mid-frame
    send_byte(8'hA3);
  endtask

  // long receiver hold-off while the sender keeps offering a long frame
  task automatic test_backpressure();
    settle();
    write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
    rx_mode   = RX_ALWAYS;
    tx_gaps   = 1'b0;
    hold_left = 200;
    send_byte(KISS_FEND);
    send_byte(8'h07);
    repeat (60) send_byte(8'($urandom_range(0, 255)) & 8'h7F);
    send_byte(KISS_FEND);
  endtask

  task automatic test_random();
    logic [15:0] cap;
    int          start;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0:       cap = 16'd1;
        1:       cap = 16'd2;
        2:       cap = 16'($urandom_range(1, 8));
        3:       cap = 16'hFFFF;
        4:       cap = 16'($urandom_range(3, 16));
        default: cap = 16'($urandom_range(1, 65535));
      endcase
      write_reg(CFG_MAX_PAYLOAD, cap);
      // one phase with no idling on either side
      rx_mode = (ph == 3) ? RX_ALWAYS : ((ph % 2) ? RX_PATTERN : RX_RANDOM);
      tx_gaps = (ph != 3);
      if (ph == 2) begin
        write_reg(CFG_PORT_OPEN, 16'd0);
        repeat (16) send_byte(8'($urandom_range(0, 255)));
        settle();
        write_reg(CFG_PORT_OPEN, 16'd1);
      end
      start = n_sent;
      while (n_sent - start < 75) send_frame(cap);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_PORT_OPEN;
    cfg_data  = 16'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_closed_port();
    test_framing();
    test_capacity();
    test_backpressure();
    test_random();

    settle();
    if (exp_events.size() != 0) begin
      $error("%0d expected events never arrived", exp_events.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/kfd_pkg.sv
src/kfd_parser.sv
src/kiss_frame_deframer.sv
bench/tb.sv
